@@ hdl/uvl_pkg.sv @@
// Shared widths, command and status codes, and sequencer states for the unique value list.
package uvl_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 8;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POSITION = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT
   } state_type;

endpackage

@@ hdl/uvl_ram.sv @@
// Entry store: one write port and one registered read port.
module uvl_ram import uvl_pkg::*; #(
   parameter int DEPTH  = CAPACITY_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DATA_W = VALUE_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/unique_value_list_engine.sv @@
// Top level of the unique value list: request sequencer, entry count and result register.
//
// A request is taken when start is high and busy is low. Add and update scan the stored
// entries for the value, one entry per cycle through the single read port of the entry
// store and one comparator, and busy stays high for the whole scan. Delete moves every
// later entry down one place, one entry per cycle, and stays busy for the whole shift. A
// request with a position out of range or an unused command code does not go busy. The
// result beat appears in the same cycle as busy falls, or after the accepting edge for a
// request that did not go busy, and rsp_valid is high for exactly that one cycle. The
// receiver cannot stall: the beat is lost if it is not taken then. A new request may be
// started in the same cycle as the result beat.
module unique_value_list_engine import uvl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     dst_ff, dst_in;
   logic                 pend_ff, pend_in;
   logic                 match_ff, match_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [VALUE_W-1:0]   ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [VALUE_W-1:0]   ram_rdata;
   logic                 bad_pos;
   logic                 hit_now;

   uvl_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W),
      .DATA_W (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      dst_ff        <= dst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign bad_pos = CMP_W'(req_position) >= CMP_W'(count_ff);
   assign hit_now = match_ff | (pend_ff && (ram_rdata == value_ff));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      dst_in        = dst_ff;
      pend_in       = 1'b0;
      match_in      = match_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = dst_ff;
      ram_wdata     = value_ff;
      ram_raddr     = scan_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in        = req_command;
               value_in      = req_value;
               scan_in       = '0;
               match_in      = 1'b0;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_status_in = STATUS_DONE;
               case (req_command)
                  CMD_ADD: begin
                     state_in = S_SEARCH;
                  end
                  CMD_UPDATE: begin
                     if (bad_pos) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_POSITION;
                     end else begin
                        dst_in   = IDX_W'(req_position);
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_DELETE: begin
                     if (bad_pos) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_POSITION;
                     end else begin
                        dst_in   = IDX_W'(req_position);
                        scan_in  = CNT_W'(req_position) + CNT_W'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            match_in = hit_now;
            if (scan_ff < count_ff) begin
               pend_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_status_in = STATUS_DONE;
               if (match_ff) begin
                  rsp_status_in = STATUS_PRESENT;
               end else if (cmd_ff == CMD_ADD) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ram_we       = 1'b1;
                     ram_waddr    = count_ff[IDX_W-1:0];
                     count_in     = count_ff + CNT_W'(1);
                     rsp_count_in = COUNT_W'(count_ff + CNT_W'(1));
                  end
               end else begin
                  ram_we = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               dst_in    = dst_ff + IDX_W'(1);
            end
            if (scan_ff < count_ff) begin
               pend_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in      = S_IDLE;
               count_in      = count_ff - CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = COUNT_W'(count_ff - CNT_W'(1));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result beat issued while the sequencer is busy.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds the capacity.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("Accepted request neither went busy nor produced a result.");

   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("Sequencer finished a request without a result beat.");

endmodule
